@@ rtl/ps2_mouse_packet_cursor_tracker_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the PS/2 mouse cursor tracker checker
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_TOP_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_TOP_MACROS_SVH

// same-cycle implication
`define PS2M_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PS2M_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ps2m_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2m_pkg
// Shared types and constants of the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2m_pkg;

	localparam int POS_BITS_DEFAULT = 12;

	localparam int BYTE_BITS   = 8;
	localparam int CFG_BITS    = 13;
	localparam int CFG_IDX_BITS = 1;
	localparam int CURSOR_BITS = 12;
	localparam int BTN_BITS    = 3;
	localparam int OUT_BITS    = 2 * CURSOR_BITS + BTN_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	// header byte layout
	localparam int HDR_SYNC_BIT = 3;
	localparam int HDR_XSGN_BIT = 4;
	localparam int HDR_YSGN_BIT = 5;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_X_BOUND = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_Y_BOUND = 1'd1;

	localparam logic [CFG_BITS-1:0] X_BOUND_RST = 13'd800;
	localparam logic [CFG_BITS-1:0] Y_BOUND_RST = 13'd600;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_XMOVE  = 2'd1,
		PH_YMOVE  = 2'd2
	} ps2m_phase_t;

	typedef struct packed {
		logic                   done;
		logic [CURSOR_BITS-1:0] cursor_x;
		logic [CURSOR_BITS-1:0] cursor_y;
		logic [BTN_BITS-1:0]    button_bits;
	} ps2m_result_t;

endpackage

`default_nettype wire

@@ rtl/ps2m_core.sv @@
// ----------------------------------------------------------------------------
// ps2m_core
// Packet framing state and cursor add-and-clamp for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2m_core
	import ps2m_pkg::*;
#(
	parameter int POS_BITS = POS_BITS_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [BYTE_BITS-1:0] rx_byte,
	input  wire logic [CFG_BITS-1:0]  x_bound,
	input  wire logic [CFG_BITS-1:0]  y_bound,
	output ps2m_result_t              res
);

	localparam int unsigned PosLimit = 1 << POS_BITS;
	localparam int unsigned XCentre = 32'(X_BOUND_RST) / 2;
	localparam int unsigned YCentre = 32'(Y_BOUND_RST) / 2;
	localparam logic [POS_BITS-1:0] PosXRst =
		POS_BITS'((XCentre >= PosLimit) ? PosLimit - 1 : XCentre);
	localparam logic [POS_BITS-1:0] PosYRst =
		POS_BITS'((YCentre >= PosLimit) ? PosLimit - 1 : YCentre);
	localparam logic [16:0] BoundMax = 17'(PosLimit);

	ps2m_phase_t          phase_q, phase_nxt;
	logic [BYTE_BITS-1:0] header_q;
	logic [BYTE_BITS-1:0] xbyte_q;
	logic [POS_BITS-1:0]  pos_x_q, pos_y_q;
	logic [POS_BITS-1:0]  new_x, new_y;
	logic                 load_header, load_xbyte, load_pos;

	// next phase
	always_comb begin
		case (phase_q)
			PH_XMOVE: phase_nxt = PH_YMOVE;
			PH_YMOVE: phase_nxt = PH_HEADER;
			default:  phase_nxt = rx_byte[HDR_SYNC_BIT] ? PH_XMOVE : PH_HEADER;
		endcase
	end

	// outputs of the framing fsm
	always_comb begin
		load_header = 1'b0;
		load_xbyte  = 1'b0;
		load_pos    = 1'b0;
		case (phase_q)
			PH_XMOVE: load_xbyte = 1'b1;
			PH_YMOVE: load_pos   = 1'b1;
			default:  load_header = 1'b1;
		endcase
	end

	// effective bound: zero acts as one, capped at the position range
	function automatic logic [POS_BITS:0] eff_bound(input logic [CFG_BITS-1:0] b);
		logic [16:0] w;
		w = {{(17-CFG_BITS){1'b0}}, b};
		if (b == '0) begin
			w = 17'd1;
		end else if (w > BoundMax) begin
			w = BoundMax;
		end
		return w[POS_BITS:0];
	endfunction

	function automatic logic [POS_BITS-1:0] clamp_pos(
		input logic [POS_BITS+1:0] v,
		input logic [POS_BITS:0]   bound
	);
		logic [POS_BITS:0] bm1;
		bm1 = bound - 1'b1;
		if (v[POS_BITS+1]) begin
			return '0;
		end else if (v[POS_BITS:0] >= bound) begin
			return bm1[POS_BITS-1:0];
		end else begin
			return v[POS_BITS-1:0];
		end
	endfunction

	logic [POS_BITS+1:0] dx, dy, sum_x, sum_y;
	logic                sx, sy;

	always_comb begin
		sx = header_q[HDR_XSGN_BIT];
		sy = header_q[HDR_YSGN_BIT];
		dx = {{(POS_BITS-7){sx}}, sx, xbyte_q};
		dy = {{(POS_BITS-7){sy}}, sy, rx_byte};
		sum_x = {2'b00, pos_x_q} + dx;
		sum_y = {2'b00, pos_y_q} - dy;
		new_x = clamp_pos(sum_x, eff_bound(x_bound));
		new_y = clamp_pos(sum_y, eff_bound(y_bound));
	end

	logic [POS_BITS+CURSOR_BITS-1:0] ext_x, ext_y;
	assign ext_x = {{CURSOR_BITS{1'b0}}, new_x};
	assign ext_y = {{CURSOR_BITS{1'b0}}, new_y};

	assign res.done        = load_pos;
	assign res.cursor_x    = ext_x[CURSOR_BITS-1:0];
	assign res.cursor_y    = ext_y[CURSOR_BITS-1:0];
	assign res.button_bits = header_q[BTN_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			header_q <= '0;
			xbyte_q  <= '0;
			pos_x_q  <= PosXRst;
			pos_y_q  <= PosYRst;
		end else if (step) begin
			phase_q <= phase_nxt;
			if (load_header) begin
				header_q <= rx_byte;
			end
			if (load_xbyte) begin
				xbyte_q <= rx_byte;
			end
			if (load_pos) begin
				pos_x_q <= new_x;
				pos_y_q <= new_y;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/ps2_mouse_packet_cursor_tracker_top.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_top
// PS/2 mouse three-byte packet decoder with clamped cursor tracking.
// ----------------------------------------------------------------------------
// Takes one received mouse byte per cycle unless stalled. Bytes are framed into
// packets of header, X move and Y move; a header must have bit 3 set, other
// bytes are dropped while waiting for one. The third byte of a packet
// yields one result (cursor x, cursor y, buttons) through the input register
// and the result register with a combinational add and clamp between them, so
// the block sustains one byte per clock unless a full result register stalls
// the input, which only happens when the waiting byte would complete a packet.
// The user must write screen bounds via the cfg port while idle; not enforced.
`default_nettype none

module ps2_mouse_packet_cursor_tracker_top
	import ps2m_pkg::*;
#(
	parameter int POS_BITS = POS_BITS_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [BYTE_BITS-1:0]      s_axis_tdata,   // [7:0] rx_byte
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// [11:0] cursor_x, [23:12] cursor_y, [26:24] button_bits, rest zero
	output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [CFG_BITS-1:0]       cfg_data
);

	logic [CFG_BITS-1:0]  x_bound_q, y_bound_q;
	logic [BYTE_BITS-1:0] rx_byte_s1;
	logic                 valid_s1;
	ps2m_result_t         res;
	ps2m_result_t         result_s2;
	logic                 valid_s2;
	logic                 out_free, advance;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_bound_q <= X_BOUND_RST;
			y_bound_q <= Y_BOUND_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_X_BOUND: x_bound_q <= cfg_data;
				CFG_Y_BOUND: y_bound_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && (!res.done || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			rx_byte_s1 <= s_axis_tdata;
		end
	end

	ps2m_core #(
		.POS_BITS(POS_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (rx_byte_s1),
		.x_bound (x_bound_q),
		.y_bound (y_bound_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && res.done;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res.done) begin
			result_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_TDATA_BITS-OUT_BITS){1'b0}},
		result_s2.button_bits, result_s2.cursor_y, result_s2.cursor_x};

endmodule

`default_nettype wire

@@ rtl/ps2m_checker.sv @@
// ----------------------------------------------------------------------------
// ps2m_checker
// Port-level checks of the PS/2 mouse cursor tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ps2_mouse_packet_cursor_tracker_top_macros.svh"

module ps2m_checker
	import ps2m_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_axis_tvalid,
	input wire logic                      s_axis_tready,
	input wire logic                      m_axis_tvalid,
	input wire logic                      m_axis_tready,
	input wire logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

	// stalled result holds
	`PS2M_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

	// pad bits are zero
	`PS2M_ASSERT_IMP(a_out_pad, m_axis_tvalid, m_axis_tdata[OUT_TDATA_BITS-1:OUT_BITS] == '0, "nonzero pad bits")

	// empty result register never blocks the input
	`PS2M_ASSERT_IMP(a_in_ready, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")

	// a new result follows an accepted input request
	`PS2M_ASSERT_IMP(a_out_cause, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without input request")

endmodule

bind ps2_mouse_packet_cursor_tracker_top ps2m_checker u_ps2m_checker (.*);

`default_nettype wire
